// ===== rtl/tss_pkg.sv =====
// tss_pkg: shared beat types and Q16.16 helpers for the tridiagonal solver.
// No dependencies.
package tss_pkg;

    localparam int QW    = 32;   // Q16.16 word
    localparam int IDXW  = 6;    // row index on the result beat
    localparam int FRAC  = 16;
    localparam int PW    = 64;   // product width

    typedef struct packed {
        logic signed [QW-1:0] lower_coef;
        logic signed [QW-1:0] main_coef;
        logic signed [QW-1:0] upper_coef;
        logic signed [QW-1:0] rhs_value;
        logic                 last_row;
    } t_row_in;

    typedef struct packed {
        logic signed [QW-1:0] solution_value;
        logic [IDXW-1:0]      row_index;
        logic                 pivot_fault;
        logic                 last_result;
    } t_result;

    // divide by 2^16, truncating toward zero
    function automatic logic signed [PW-1:0] q_trunc(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] adj;
        adj = p[PW-1] ? (p + PW'(65535)) : p;
        return adj >>> FRAC;
    endfunction

    function automatic logic signed [QW-1:0] sat32(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] hi;
        logic signed [PW-1:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[QW-1:0];
    endfunction

endpackage

// ===== rtl/tridiagonal_system_solver_top.sv =====
// tridiagonal_system_solver_top: streaming Thomas-algorithm solver, Q16.16.
// Depends on tss_pkg, tss_ram, tss_div.
//
//  channel | direction | handshake                | beat
//  --------+-----------+--------------------------+--------------------------
//  in      | sink      | i_in_valid / o_in_stall  | t_row_in, one matrix row
//  out     | source    | o_out_valid / i_out_stall| t_result, one solution
//
// Each row passes from the accept in S_IDLE through S_MUL_U and S_MUL_R, the
// multiplies for the pivot and the rhs numerator, the divider start in S_NUM,
// the serial divide in S_DIV (both ratios in parallel), then the ratio write
// in S_WR. A zero pivot skips the dividers.
// After the last row, each solution beat but the final one passes through
// output, multiply and subtract, plus any output stall.
// Synchronous active-low reset clears the control state; the ratio RAM is
// never cleared since only entries of the current system are read.
// The input stalls whenever the block is not idle.
module tridiagonal_system_solver_top
    import tss_pkg::*;
#(
    parameter int MAX_ROWS = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_row_in i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_out_data
);
    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL_U = 8'b0000_0010,
        S_MUL_R = 8'b0000_0100,
        S_NUM   = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_WR    = 8'b0010_0000,
        S_OUT   = 8'b0100_0000,
        S_BSUB  = 8'b1000_0000
    } t_state;

    t_state r_state;
    logic   r_bmul;     // back-substitution multiply cycle pending

    // latched row
    logic signed [QW-1:0] r_a, r_b, r_c, r_d;
    logic                 r_last;

    // elimination state
    logic signed [QW-1:0] r_pu, r_pr;
    logic [AW-1:0]        r_row;
    logic                 r_fault;

    // datapath registers
    logic signed [PW-1:0] r_prod;
    logic signed [QW-1:0] r_piv;
    logic signed [QW-1:0] r_ur, r_dr;
    logic signed [QW-1:0] r_x;
    logic signed [QW-1:0] r_bdr;
    logic [AW-1:0]        r_idx;

    logic signed [QW-1:0] m_a, m_b;
    logic signed [QW-1:0] n_piv, n_num, n_x;
    logic                 div_start;
    logic                 div_done_u, div_done_r;
    logic signed [QW-1:0] div_q_u, div_q_r;
    logic [2*QW-1:0]      rd_data;
    logic signed [QW-1:0] rd_ur, rd_dr;
    logic                 in_acc, out_acc;

    assign in_acc  = i_in_valid && (r_state == S_IDLE);
    assign out_acc = (r_state == S_OUT) && !i_out_stall;

    assign rd_ur = rd_data[2*QW-1:QW];
    assign rd_dr = rd_data[QW-1:0];

    // shared multiplier operand select
    always_comb begin
        m_a = r_a;
        m_b = r_pu;
        if (r_state == S_MUL_R)
            m_b = r_pr;
        else if (r_bmul) begin
            m_a = r_x;
            m_b = rd_ur;
        end
    end

    assign n_piv = sat32($signed({{QW{r_b[QW-1]}}, r_b}) - q_trunc(r_prod));
    assign n_num = sat32($signed({{QW{r_d[QW-1]}}, r_d}) - q_trunc(r_prod));
    assign n_x   = sat32($signed({{QW{r_bdr[QW-1]}}, r_bdr}) - q_trunc(r_prod));

    assign div_start = (r_state == S_NUM) && (r_piv != '0);

    tss_div u_div_upper (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_c),
        .i_den   (r_piv),
        .o_done  (div_done_u),
        .o_quot  (div_q_u)
    );

    tss_div u_div_rhs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (n_num),
        .i_den   (r_piv),
        .o_done  (div_done_r),
        .o_quot  (div_q_r)
    );

    // ratio store: {upper ratio, rhs ratio} per row
    tss_ram #(
        .W (2*QW),
        .D (MAX_ROWS)
    ) u_ratio_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WR),
        .i_waddr (r_row),
        .i_wdata ({r_ur, r_dr}),
        .i_raddr (r_idx - AW'(1)),
        .o_rdata (rd_data)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bmul  <= 1'b0;
            r_pu    <= '0;
            r_pr    <= '0;
            r_row   <= '0;
            r_fault <= 1'b0;
        end else begin
            r_bmul <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc)
                        r_state <= S_MUL_U;
                end
                S_MUL_U: r_state <= S_MUL_R;
                S_MUL_R: r_state <= S_NUM;
                S_NUM: begin
                    if (r_piv == '0) begin
                        r_fault <= 1'b1;
                        r_state <= S_WR;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done_u && div_done_r)
                        r_state <= S_WR;
                end
                S_WR: begin
                    if (r_last) begin
                        r_state <= S_OUT;
                    end else begin
                        r_pu    <= r_ur;
                        r_pr    <= r_dr;
                        r_row   <= r_row + AW'(1);
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (out_acc) begin
                        if (r_idx == '0) begin
                            r_pu    <= '0;
                            r_pr    <= '0;
                            r_row   <= '0;
                            r_fault <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_bmul  <= 1'b1;
                            r_state <= S_BSUB;
                        end
                    end
                end
                S_BSUB: begin
                    // multiply while r_bmul is set, subtract once it clears
                    if (!r_bmul)
                        r_state <= S_OUT;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
        if (in_acc) begin
            r_a    <= i_in_data.lower_coef;
            r_b    <= i_in_data.main_coef;
            r_c    <= i_in_data.upper_coef;
            r_d    <= i_in_data.rhs_value;
            // row limit forces the solve
            r_last <= i_in_data.last_row || (r_row == AW'(MAX_ROWS - 1));
        end
        if (r_state == S_MUL_R)
            r_piv <= n_piv;
        if ((r_state == S_NUM) && (r_piv == '0)) begin
            r_ur <= '0;
            r_dr <= '0;
        end
        if ((r_state == S_DIV) && div_done_u && div_done_r) begin
            r_ur <= div_q_u;
            r_dr <= div_q_r;
        end
        if ((r_state == S_WR) && r_last) begin
            r_x   <= r_dr;
            r_idx <= r_row;
        end
        if (out_acc && (r_idx != '0))
            r_idx <= r_idx - AW'(1);
        if (r_bmul)
            r_bdr <= rd_dr;
        if ((r_state == S_BSUB) && !r_bmul)
            r_x <= n_x;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    assign o_out_data.solution_value = r_fault ? '0 : r_x;
    assign o_out_data.row_index      = IDXW'(r_idx);
    assign o_out_data.pivot_fault    = r_fault;
    assign o_out_data.last_result    = (r_idx == '0);
endmodule

// ===== rtl/tss_ram.sv =====
// tss_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module tss_ram #(
    parameter int W = 64,
    parameter int D = 64
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0]  i_waddr,
    input  logic [W-1:0]                        i_wdata,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0]  i_raddr,
    output logic [W-1:0]                        o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/tss_div.sv =====
// tss_div: radix-2 restoring divider, sat32((num * 2^16) / den), toward zero.
// Depends on tss_pkg. 48 iterations, one quotient bit per cycle.
module tss_div
    import tss_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [QW-1:0] i_num,
    input  logic signed [QW-1:0] i_den,
    output logic                 o_done,
    output logic signed [QW-1:0] o_quot
);
    localparam int DW = QW + FRAC;   // dividend bits

    logic          r_busy;
    logic          r_done;
    logic [5:0]    r_cnt;
    logic          r_neg;
    logic [QW-1:0] r_den;
    logic [QW-1:0] r_rem;
    logic [DW-1:0] r_quo;

    logic [QW:0]   num_ext;
    logic [QW:0]   den_ext;
    logic [QW:0]   num_mag;
    logic [QW:0]   den_mag;
    logic [QW:0]   shl;
    logic [QW+1:0] diff;
    logic          ge;
    logic signed [PW-1:0] mag64;

    assign num_ext = {i_num[QW-1], i_num};
    assign den_ext = {i_den[QW-1], i_den};
    assign num_mag = i_num[QW-1] ? -num_ext : num_ext;
    assign den_mag = i_den[QW-1] ? -den_ext : den_ext;

    assign shl  = {r_rem, r_quo[DW-1]};
    assign diff = {1'b0, shl} - {2'b00, r_den};
    assign ge   = !diff[QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[QW-1] ^ i_den[QW-1];
            r_den <= den_mag[QW-1:0];
            r_rem <= '0;
            r_quo <= {num_mag[QW-1:0], {FRAC{1'b0}}};
        end else if (r_busy) begin
            r_rem <= ge ? diff[QW-1:0] : shl[QW-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

    assign mag64  = $signed({{(PW-DW){1'b0}}, r_quo});
    assign o_quot = sat32(r_neg ? -mag64 : mag64);
    assign o_done = r_done;
endmodule
